// ===== src/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types, constants and helpers for the wildcard byte pattern search.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int MAX_LEN_DEF = 16;

   localparam logic [7:0] HIGH_NIBBLE = 8'hF0;
   localparam logic [7:0] LOW_NIBBLE  = 8'h0F;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_START   = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [3:0] entry_index;
      logic [7:0] entry_value;
      logic [1:0] entry_wild;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic        match_found;
      logic [31:0] match_position;
   } rsp_word_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic load;
   } cell_ctrl_type;

   function automatic logic [7:0] wild_mask(input logic [1:0] wild);
      logic [7:0] m;
      m = 8'h00;
      if (wild[1]) m = m | HIGH_NIBBLE;
      if (wild[0]) m = m | LOW_NIBBLE;
      return m;
   endfunction

endpackage

// ===== src/wbps_cell.sv =====
// ----------------------------------------------------------------------------
// wbps_cell
// One window stage: holds a window byte and one signature byte with its mask.
// ----------------------------------------------------------------------------
module wbps_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wbps_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             shift_in,
   input  logic [7:0]             load_value,
   input  logic [7:0]             load_mask,
   input  logic [7:0]             probe,
   input  logic                   enable,
   output logic [7:0]             shift_out,
   output logic                   hit
);
   import wbps_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] pat_ff;
   logic [7:0] mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else if (ctrl.clear) begin
         byte_ff <= '0;
      end else if (ctrl.shift) begin
         byte_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         pat_ff  <= load_value | load_mask;
         mask_ff <= load_mask;
      end
   end

   assign shift_out = byte_ff;
   assign hit       = !enable || ((probe | mask_ff) == pat_ff);

endmodule

// ===== src/wildcard_byte_pattern_search_top.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_top
// Streaming signature search with nibble wildcards over a window of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req_word): load words write one signature
//   byte with its wildcard bits; data words push one byte of the region.
//   rsp channel (rsp_valid/rsp_stall/rsp_word): one word per region, either
//   the match offset (search_start + index of first matching byte) or
//   not-found on the last byte. Bytes after a match give nothing.
//   csr port (csr_valid/csr_ready/csr_index/csr_wdata): pattern_length and
//   search_start, always ready; write only while the block is idle.
// Timing:
//   One word accepted per cycle while req_stall is low. A result is registered
//   in the output register, or in the skid register while rsp is held. The window
//   compare, the hit tree and the offset adder are combinational, ahead of those registers.
// Reset:
//   Synchronous, active high: search state clears, pattern_length becomes 1,
//   search_start 0. Signature bytes hold nothing until loaded.
// Stall:
//   A skid register holds one result behind the output register; req_stall
//   rises while it is occupied.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_top #(
   parameter int MAX_LEN = wbps_pkg::MAX_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  wbps_pkg::req_word_type        req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output wbps_pkg::rsp_word_type        rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wbps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);
   import wbps_pkg::*;

   localparam int LEN_W = $clog2(MAX_LEN + 1);

   logic [4:0]       len_cfg_ff;
   logic [31:0]      start_ff;
   logic [31:0]      seen_ff;
   logic             found_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;
   logic             skid_valid_ff;
   rsp_word_type     skid_word_ff;

   logic [LEN_W-1:0] used_len;
   logic             req_acc;
   logic             data_acc;
   logic             load_acc;
   logic [7:0]       load_mask;
   logic [31:0]      seen_in;
   logic             full_hit;
   logic             gen;
   rsp_word_type     gen_word;
   logic             take;

   cell_ctrl_type    ctrl    [MAX_LEN];
   logic [7:0]       new_win [MAX_LEN];
   logic [7:0]       win     [MAX_LEN];
   logic [7:0]       probe   [MAX_LEN];
   logic             enable  [MAX_LEN];
   logic [MAX_LEN-1:0] hits;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= 5'd1;
         start_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: len_cfg_ff <= csr_wdata[4:0];
            CSR_SEARCH_START:   start_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (len_cfg_ff == 5'd0) begin
         used_len = LEN_W'(1);
      end else if (32'(len_cfg_ff) > MAX_LEN) begin
         used_len = LEN_W'(MAX_LEN);
      end else begin
         used_len = LEN_W'(len_cfg_ff);
      end
   end

   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign data_acc  = req_acc && (req_word.req_type == REQ_DATA);
   assign load_acc  = req_acc && (req_word.req_type == REQ_LOAD);
   assign load_mask = wild_mask(req_word.entry_wild);

   always_comb begin
      for (int k = 0; k < MAX_LEN; k++) begin
         new_win[k]    = (k == 0) ? req_word.data_byte : win[(k == 0) ? 0 : k - 1];
         enable[k]     = 32'(used_len) > k;
         ctrl[k].shift = data_acc && !found_ff;
         ctrl[k].clear = data_acc && req_word.last_byte;
         ctrl[k].load  = load_acc && (32'(req_word.entry_index) == k);
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_LEN; j++) begin
         probe[j] = '0;
         for (int k = 0; k < MAX_LEN; k++) begin
            if (k + j + 1 == 32'(used_len)) probe[j] = new_win[k];
         end
      end
   end

   for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
      wbps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl[g]),
         .shift_in   (new_win[g]),
         .load_value (req_word.entry_value),
         .load_mask  (load_mask),
         .probe      (probe[g]),
         .enable     (enable[g]),
         .shift_out  (win[g]),
         .hit        (hits[g])
      );
   end

   assign seen_in  = seen_ff + 32'd1;
   assign full_hit = (&hits) && (seen_in >= 32'(used_len));
   assign gen      = data_acc && !found_ff && (full_hit || req_word.last_byte);

   always_comb begin
      gen_word.match_found    = full_hit;
      gen_word.match_position = full_hit ? (start_ff + seen_in - 32'(used_len)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         found_ff <= 1'b0;
      end else if (data_acc) begin
         if (req_word.last_byte) begin
            seen_ff  <= '0;
            found_ff <= 1'b0;
         end else if (!found_ff) begin
            seen_ff  <= seen_in;
            found_ff <= full_hit;
         end
      end
   end

   assign take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (gen) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (gen) begin
         if (!rsp_valid_ff || take) begin
            rsp_word_ff <= gen_word;
         end else begin
            skid_word_ff <= gen_word;
         end
      end else if (take && skid_valid_ff) begin
         rsp_word_ff <= skid_word_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a word while output register is empty");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (data_acc && req_word.last_byte) |=> (seen_ff == '0 && !found_ff))
      else $error("search state not cleared after last byte");

   a_found_sticks: assert property (@(posedge clock) disable iff (reset)
      (gen && full_hit && !req_word.last_byte) |=> found_ff)
      else $error("match did not set found flag");

   a_quiet_after_found: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> !gen)
      else $error("result produced after a match");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard byte pattern search block. Signature
// loads and data bytes go in over a bursty req channel, and a scoreboard
// predicts the match offset or not-found word for each region. A directed
// opening covers the reset length, the length edge cases, a match on the last
// byte and a short region. Eight random phases follow with other settings.
// Most regions carry an embedded signature, and one phase holds off the
// receiver long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
   import wbps_pkg::*;

   localparam int SIG_DEPTH       = MAX_LEN_DEF;
   localparam int IDLE_LIMIT      = 2000;
   localparam int SQUEEZE_CYCLES  = 300;
   localparam int ITEMS_PER_PHASE = 120;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_word_type         req_word  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_word_type         rsp_word;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   class match_scoreboard;
      logic [7:0]   sig_value [SIG_DEPTH];
      logic [7:0]   sig_mask  [SIG_DEPTH];
      logic [7:0]   window    [SIG_DEPTH];
      logic [31:0]  seen;
      bit           found;
      logic [4:0]   length_reg;
      logic [31:0]  start_reg;
      rsp_word_type expected_hits [$];
      int           failures;
      int           hits;
      int           misses;

      function new();
         length_reg = 5'd1;
         start_reg  = '0;
         failures   = 0;
         hits       = 0;
         misses     = 0;
         restart();
      endfunction

      function void restart();
         foreach (window[i]) window[i] = 8'h00;
         seen  = '0;
         found = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         if (idx == CSR_PATTERN_LENGTH) length_reg = data[4:0];
         else start_reg = data;
      endfunction

      function int used_length();
         if (length_reg == 0) return 1;
         if (length_reg > SIG_DEPTH) return SIG_DEPTH;
         return int'(length_reg);
      endfunction

      function void predict_word(req_word_type w);
         int           len;
         bit           hit;
         rsp_word_type r;
         if (w.req_type == REQ_LOAD) begin
            sig_mask[w.entry_index]  = (w.entry_wild[1] ? HIGH_NIBBLE : 8'h00) |
                                       (w.entry_wild[0] ? LOW_NIBBLE : 8'h00);
            sig_value[w.entry_index] = w.entry_value | sig_mask[w.entry_index];
            return;
         end
         if (!found) begin
            for (int i = SIG_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = w.data_byte;
            seen = seen + 32'd1;
            len  = used_length();
            hit  = (seen >= 32'(len));
            for (int j = 0; j < len; j++)
               if ((window[len-1-j] | sig_mask[j]) != sig_value[j]) hit = 1'b0;
            if (hit) begin
               found            = 1'b1;
               r.match_found    = 1'b1;
               r.match_position = start_reg + seen - 32'(len);
               expected_hits.push_back(r);
            end else if (w.last_byte) begin
               r = '0;
               expected_hits.push_back(r);
            end
         end
         if (w.last_byte) restart();
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_hits.size() == 0) begin
            $error("unexpected result word: match_found %0d, match_position %h",
                   got.match_found, got.match_position);
            failures++;
            return;
         end
         want = expected_hits.pop_front();
         if (got.match_found !== want.match_found) begin
            $error("match_found: expected %0d, got %0d", want.match_found, got.match_found);
            failures++;
         end
         if (got.match_position !== want.match_position) begin
            $error("match_position: expected %h, got %h",
                   want.match_position, got.match_position);
            failures++;
         end
         if (want.match_found) hits++;
         else misses++;
      endfunction
   endclass

   match_scoreboard sb;
   int burst_left   = 0;
   int phase_items  = 0;
   int loads_sent   = 0;
   int bytes_sent   = 0;
   int settings     = 0;
   bit squeeze_on   = 1'b0;
   bit squeeze_done = 1'b0;

   wildcard_byte_pattern_search_top #(.MAX_LEN(SIG_DEPTH)) DUT (.*);

   always #2 clock = ~clock;

   always @(negedge clock)
      if (rsp_valid && !rsp_stall) sb.check_result(rsp_word);

   task automatic send_word(req_word_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      sb.predict_word(w);
      phase_items++;
      if (w.req_type == REQ_LOAD) loads_sent++;
      else bytes_sent++;
   endtask

   task automatic offer(req_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (squeeze_on) gap = 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_word(w);
   endtask

   function automatic req_word_type noise_word();
      logic [31:0] r;
      r = $urandom;
      return req_word_type'(r[$bits(req_word_type)-1:0]);
   endfunction

   task automatic send_byte(logic [7:0] d, logic last);
      req_word_type w;
      w           = noise_word();
      w.req_type  = REQ_DATA;
      w.data_byte = d;
      w.last_byte = last;
      offer(w);
   endtask

   task automatic send_entry(logic [3:0] idx, logic [7:0] v, logic [1:0] wild);
      req_word_type w;
      w             = noise_word();
      w.req_type    = REQ_LOAD;
      w.entry_index = idx;
      w.entry_value = v;
      w.entry_wild  = wild;
      offer(w);
   endtask

   // data byte that satisfies signature entry j, wildcard nibbles random
   function automatic logic [7:0] fitting_byte(int j);
      return (sb.sig_value[j] & ~sb.sig_mask[j]) | (8'($urandom) & sb.sig_mask[j]);
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_hits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(logic [31:0] len, logic [31:0] start);
      settle();
      write_reg(CSR_PATTERN_LENGTH, len);
      write_reg(CSR_SEARCH_START, start);
      settings++;
   endtask

   task automatic send_region();
      int len;
      int kind;
      int pre;
      int post;
      int n;
      len  = sb.used_length();
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         pre  = $urandom_range(0, 8);
         post = $urandom_range(0, 4);
         repeat (pre) send_byte(8'($urandom), 1'b0);
         for (int j = 0; j < len; j++)
            send_byte(fitting_byte(j), post == 0 && j == len - 1);
         for (int k = 1; k <= post; k++) send_byte(8'($urandom), k == post);
      end else if (kind == 7) begin
         n = $urandom_range(1, 20);
         for (int k = 1; k <= n; k++) send_byte(8'($urandom), k == n);
      end else if (kind == 8) begin
         // region ends before the signature completes, unless the length is one
         n = (len > 1) ? $urandom_range(1, len - 1) : 1;
         for (int j = 0; j < n; j++) send_byte(fitting_byte(j), j == n - 1);
      end else begin
         // one random signature entry reloaded partway through the region
         n = $urandom_range(0, len - 1);
         for (int j = 0; j < n; j++) send_byte(fitting_byte(j), 1'b0);
         send_entry(4'($urandom), 8'($urandom), 2'($urandom));
         for (int j = n; j < len; j++) send_byte(fitting_byte(j), j == len - 1);
      end
   endtask

   task automatic run_phase(logic [31:0] len, logic [31:0] start, bit squeeze);
      apply_setting(len, start);
      repeat ($urandom_range(0, 6)) send_entry(4'($urandom), 8'($urandom), 2'($urandom));
      if (squeeze) begin
         squeeze_on = 1'b1;
         repeat (40) send_byte(8'($urandom), 1'b1);
         squeeze_on = 1'b0;
      end
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) send_region();
   endtask

   initial begin
      int run;
      int kind;
      @(posedge clock);
      forever begin
         if (squeeze_on && !squeeze_done) begin
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            squeeze_done = 1'b1;
         end
         run  = $urandom_range(5, 60);
         kind = $urandom_range(0, 3);
         repeat (run) begin
            case (kind)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
            @(posedge clock);
            if (squeeze_on && !squeeze_done) break;
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(negedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) idle = 0;
         else idle++;
      end
      $error("no word moved for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int j = 0; j < SIG_DEPTH; j++) send_entry(4'(j), 8'(j * 17), 2'(j % 4));
      // reset length of one: miss, hit on last byte, hit then ignored bytes
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b1);
      // zero length acts as one; offset wraps
      apply_setting(32'd0, 32'hFFFF_FFFF);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b1);
      // short region, then a match through both nibble wildcards
      apply_setting(32'd4, 32'h0000_0010);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h1A, 1'b0);
      send_byte(8'h72, 1'b0);
      send_byte(8'hC4, 1'b1);

      run_phase(32'd16, 32'hFFFF_FFFF, 1'b0);
      run_phase(32'd31, 32'h0000_0000, 1'b1);
      run_phase(32'd3,  32'hFFFF_FFF8, 1'b0);
      run_phase(32'd17, $urandom, 1'b0);
      run_phase(32'd1,  32'h8000_0000, 1'b0);
      run_phase($urandom_range(2, 15), $urandom, 1'b0);
      run_phase(32'd0,  32'hFFFF_FFFF, 1'b0);
      run_phase(32'd7,  32'hFFFF_FFF0, 1'b0);
      settle();

      $display("Covered %0d signature loads and %0d data bytes over %0d register settings.",
               loads_sent, bytes_sent, settings);
      $display("Checked %0d match offsets and %0d not-found words.", sb.hits, sb.misses);
      if (sb.failures == 0 && sb.expected_hits.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== wildcard_byte_pattern_search_top.f =====
src/wbps_pkg.sv
src/wbps_cell.sv
src/wildcard_byte_pattern_search_top.sv
verif/tb.sv
